@@ rtl/heightmap_triangle_sampler_core_defines.svh @@
// Assertion macros shared by the heightmap triangle sampler modules.
`ifndef HEIGHTMAP_TRIANGLE_SAMPLER_CORE_DEFINES_SVH
`define HEIGHTMAP_TRIANGLE_SAMPLER_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define HTS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define HTS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define HTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/htsamp_pkg.sv @@
// Shared constants, codes and types of the heightmap triangle sampler.
package htsamp_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_DEPTH  = 256;
    localparam int XB         = $clog2(MAX_WIDTH);
    localparam int ZB         = $clog2(MAX_DEPTH);
    localparam int BANK_DEPTH = (MAX_WIDTH / 2) * (MAX_DEPTH / 2);
    localparam int BANK_AW    = (XB - 1) + (ZB - 1);

    localparam int DIM_W   = 9;
    localparam int INV_W   = 24;
    localparam int SY_W    = 16;
    localparam int POS_W   = 24;
    localparam int FRAC_W  = 16;
    localparam int HGT_W   = 8;
    localparam int OUT_W   = 32;
    localparam int CFG_W   = 24;
    localparam int CIDX_W  = 3;
    localparam int IN_W    = 72;

    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_GRID_DEPTH  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_INV_SCALE_X = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_INV_SCALE_Z = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_SCALE_Y     = 3'd4;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // which corner is rebuilt to make the cell planar
    localparam logic [1:0] REPL_BR = 2'd0;
    localparam logic [1:0] REPL_TL = 2'd1;
    localparam logic [1:0] REPL_TR = 2'd2;
    localparam logic [1:0] REPL_BL = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0] grid_width;
        logic [DIM_W-1:0] grid_depth;
        logic [INV_W-1:0] inv_scale_x;
        logic [INV_W-1:0] inv_scale_z;
        logic [SY_W-1:0]  scale_y;
    } cfg_t;

    typedef struct packed {
        logic              is_query;
        logic              wr_en;
        logic              in_range;
        logic [1:0]        repl;
        logic [XB-1:0]     x;
        logic [ZB-1:0]     z;
        logic [FRAC_W-1:0] xf;
        logic [FRAC_W-1:0] zf;
        logic [HGT_W-1:0]  value;
    } cmd_t;

endpackage

@@ rtl/htsamp_front.sv @@
// Front end: accept requests, scale positions and classify them into commands.
module htsamp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  htsamp_pkg::cfg_t       cfg,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [htsamp_pkg::IN_W-1:0] s_tdata,
    input  logic                   s_tuser,
    output logic                   push,
    output htsamp_pkg::cmd_t       push_data,
    input  logic                   full
);

    localparam int GP_W  = htsamp_pkg::POS_W + htsamp_pkg::INV_W;
    localparam int INT_W = GP_W - htsamp_pkg::INV_W;
    localparam int FR_LO = htsamp_pkg::INV_W - htsamp_pkg::FRAC_W;

    logic                                   accept;
    logic                                   s1_valid_reg;
    logic                                   s1_valid_next;
    logic                                   s1_op_reg;
    logic [7:0]                             s1_sx_reg;
    logic [7:0]                             s1_sz_reg;
    logic [htsamp_pkg::HGT_W-1:0]           s1_val_reg;
    logic signed [GP_W-1:0]                 s1_gx_reg;
    logic signed [GP_W-1:0]                 s1_gz_reg;

    logic signed [htsamp_pkg::POS_W-1:0]    pos_x;
    logic signed [htsamp_pkg::POS_W-1:0]    pos_z;
    logic signed [htsamp_pkg::INV_W:0]      inv_x;
    logic signed [htsamp_pkg::INV_W:0]      inv_z;
    logic signed [GP_W:0]                   gx_full;
    logic signed [GP_W:0]                   gz_full;

    logic [htsamp_pkg::DIM_W-1:0]           w_eff;
    logic [htsamp_pkg::DIM_W-1:0]           d_eff;
    logic                                   dims_ok;
    logic [INT_W-1:0]                       gx_int;
    logic [INT_W-1:0]                       gz_int;
    logic                                   x_in;
    logic                                   z_in;
    logic                                   q_in_range;
    logic [htsamp_pkg::XB-1:0]              xi;
    logic [htsamp_pkg::ZB-1:0]              zi;
    logic [htsamp_pkg::FRAC_W-1:0]          xf;
    logic [htsamp_pkg::FRAC_W-1:0]          zf;
    logic [htsamp_pkg::FRAC_W:0]            fsum;
    logic [1:0]                             repl;
    logic                                   ld_ok;
    logic [htsamp_pkg::DIM_W-1:0]           ld_row;

    assign s_tready = !s1_valid_reg || !full;
    assign accept   = s_tvalid && s_tready;
    assign push     = s1_valid_reg && !full;

    assign pos_x   = s_tdata[24 +: htsamp_pkg::POS_W];
    assign pos_z   = s_tdata[48 +: htsamp_pkg::POS_W];
    assign inv_x   = $signed({1'b0, cfg.inv_scale_x});
    assign inv_z   = $signed({1'b0, cfg.inv_scale_z});
    assign gx_full = pos_x * inv_x;
    assign gz_full = pos_z * inv_z;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // scale the position once on entry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg <= s_tuser;
            s1_sx_reg <= s_tdata[7:0];
            s1_sz_reg <= s_tdata[15:8];
            s1_val_reg <= s_tdata[23:16];
            s1_gx_reg <= gx_full[GP_W-1:0];
            s1_gz_reg <= gz_full[GP_W-1:0];
        end
    end

    // oversized grid dimensions clamp to the store size
    assign w_eff = (32'(cfg.grid_width) > 32'(htsamp_pkg::MAX_WIDTH)) ?
                   htsamp_pkg::DIM_W'(htsamp_pkg::MAX_WIDTH) : cfg.grid_width;
    assign d_eff = (32'(cfg.grid_depth) > 32'(htsamp_pkg::MAX_DEPTH)) ?
                   htsamp_pkg::DIM_W'(htsamp_pkg::MAX_DEPTH) : cfg.grid_depth;
    assign dims_ok = (w_eff >= htsamp_pkg::DIM_W'(2)) && (d_eff >= htsamp_pkg::DIM_W'(2));

    assign gx_int = s1_gx_reg[GP_W-1:htsamp_pkg::INV_W];
    assign gz_int = s1_gz_reg[GP_W-1:htsamp_pkg::INV_W];
    assign x_in   = !s1_gx_reg[GP_W-1] && (gx_int < (INT_W'(w_eff) - INT_W'(1)));
    assign z_in   = !s1_gz_reg[GP_W-1] && (gz_int < (INT_W'(d_eff) - INT_W'(1)));
    assign q_in_range = dims_ok && x_in && z_in;

    assign xi = s1_gx_reg[htsamp_pkg::INV_W +: htsamp_pkg::XB];
    assign zi = s1_gz_reg[htsamp_pkg::INV_W +: htsamp_pkg::ZB];
    assign xf = s1_gx_reg[FR_LO +: htsamp_pkg::FRAC_W];
    assign zf = s1_gz_reg[FR_LO +: htsamp_pkg::FRAC_W];
    assign fsum = {1'b0, xf} + {1'b0, zf};

    // even rows split along one diagonal, odd rows along the other
    always_comb
    begin
        if (!zi[0])
        begin
            repl = (zf >= xf) ? htsamp_pkg::REPL_BR : htsamp_pkg::REPL_TL;
        end
        else
        begin
            repl = fsum[htsamp_pkg::FRAC_W] ? htsamp_pkg::REPL_BL : htsamp_pkg::REPL_TR;
        end
    end

    // loads land with their row flipped; drop those outside the grid
    assign ld_ok  = (htsamp_pkg::DIM_W'(s1_sx_reg) < w_eff) &&
                    (htsamp_pkg::DIM_W'(s1_sz_reg) < d_eff);
    assign ld_row = d_eff - htsamp_pkg::DIM_W'(1) - htsamp_pkg::DIM_W'(s1_sz_reg);

    always_comb
    begin
        push_data.is_query = (s1_op_reg == htsamp_pkg::OP_QUERY);
        push_data.wr_en    = (s1_op_reg == htsamp_pkg::OP_LOAD) && ld_ok;
        push_data.in_range = (s1_op_reg == htsamp_pkg::OP_QUERY) && q_in_range;
        push_data.repl     = repl;
        push_data.x        = (s1_op_reg == htsamp_pkg::OP_QUERY) ? xi :
                             htsamp_pkg::XB'(s1_sx_reg);
        push_data.z        = (s1_op_reg == htsamp_pkg::OP_QUERY) ? zi :
                             htsamp_pkg::ZB'(ld_row);
        push_data.xf       = xf;
        push_data.zf       = zf;
        push_data.value    = s1_val_reg;
    end

endmodule

@@ rtl/htsamp_queue.sv @@
// Command queue between the front end and the back end.
`include "heightmap_triangle_sampler_core_defines.svh"

module htsamp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  htsamp_pkg::cmd_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output htsamp_pkg::cmd_t head
);

    htsamp_pkg::cmd_t              slot_reg [htsamp_pkg::QDEPTH];
    logic [htsamp_pkg::QAW-1:0]    wr_ptr_reg;
    logic [htsamp_pkg::QAW-1:0]    rd_ptr_reg;
    logic [htsamp_pkg::QAW:0]      count_reg;
    logic [htsamp_pkg::QAW:0]      count_next;

    assign full  = (count_reg == (htsamp_pkg::QAW + 1)'(htsamp_pkg::QDEPTH));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + (htsamp_pkg::QAW + 1)'(1);
            2'b01:   count_next = count_reg - (htsamp_pkg::QAW + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + htsamp_pkg::QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + htsamp_pkg::QAW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `HTS_ASSERT_ALWAYS(a_count_bound, count_reg <= (htsamp_pkg::QAW + 1)'(htsamp_pkg::QDEPTH), "queue count overflow")
    `HTS_ASSERT_IMPLY(a_no_push_full, full, !push, "push into full queue")
    `HTS_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

@@ rtl/htsamp_back.sv @@
// Back end: banked height store, planar corner fix-up, interpolation and scaling.
`include "heightmap_triangle_sampler_core_defines.svh"

module htsamp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [htsamp_pkg::SY_W-1:0]   scale_y,
    input  logic                          q_valid,
    input  htsamp_pkg::cmd_t              q_data,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [htsamp_pkg::OUT_W-1:0]  m_tdata,
    output logic                          m_tuser
);

    localparam int CW     = htsamp_pkg::HGT_W + 2;
    localparam int DW     = CW + 1;
    localparam int FW     = htsamp_pkg::FRAC_W + 1;
    localparam int TOP_W  = htsamp_pkg::FRAC_W + DW + 2;
    localparam int DIFF_W = TOP_W + 1;
    localparam int H_W    = DIFF_W + FW + 1;
    localparam int HU_W   = htsamp_pkg::HGT_W + 2 * htsamp_pkg::FRAC_W;
    localparam int HALF   = HU_W / 2;
    localparam int PP_W   = HALF + htsamp_pkg::SY_W;
    localparam int SUM_W  = HU_W + htsamp_pkg::SY_W;

    logic                                 adv;
    logic [3:0]                           bank_we;
    logic [htsamp_pkg::HGT_W-1:0]         rd_data_reg [4];

    // stage 1: corner reads
    logic                                 b1_valid_reg;
    logic                                 b1_in_range_reg;
    logic [1:0]                           b1_repl_reg;
    logic                                 b1_x0_reg;
    logic                                 b1_z0_reg;
    logic [htsamp_pkg::FRAC_W-1:0]        b1_xf_reg;
    logic [htsamp_pkg::FRAC_W-1:0]        b1_zf_reg;

    // stage 2: row heights
    logic signed [CW-1:0]                 bl;
    logic signed [CW-1:0]                 br;
    logic signed [CW-1:0]                 tl;
    logic signed [CW-1:0]                 tr;
    logic signed [TOP_W-1:0]              tl_w;
    logic signed [TOP_W-1:0]              bl_w;
    logic signed [DW-1:0]                 d_top;
    logic signed [DW-1:0]                 d_bot;
    logic signed [FW-1:0]                 xf_s;
    logic signed [TOP_W-1:0]              top;
    logic signed [TOP_W-1:0]              bot;
    logic                                 b2_valid_reg;
    logic                                 b2_in_range_reg;
    logic [htsamp_pkg::FRAC_W-1:0]        b2_zf_reg;
    logic signed [TOP_W-1:0]              b2_top_reg;
    logic signed [TOP_W-1:0]              b2_bot_reg;

    // stage 3: cell height
    logic signed [DIFF_W-1:0]             diff;
    logic signed [H_W-1:0]                bot_h;
    logic signed [FW-1:0]                 zf_s;
    logic signed [H_W-1:0]                h;
    logic                                 b3_valid_reg;
    logic                                 b3_in_range_reg;
    logic signed [H_W-1:0]                b3_h_reg;

    // stage 4: vertical scale, split in two partial products
    logic [HU_W-1:0]                      hu;
    logic                                 b4_valid_reg;
    logic                                 b4_in_range_reg;
    logic [PP_W-1:0]                      b4_lo_reg;
    logic [PP_W-1:0]                      b4_hi_reg;

    // stage 5: output register
    logic [SUM_W-1:0]                     sum;
    logic                                 b5_valid_reg;
    logic                                 b5_in_range_reg;
    logic [htsamp_pkg::OUT_W-1:0]         b5_height_reg;

    // the whole back end moves as one; stall only on the output
    assign adv = !b5_valid_reg || m_tready;
    assign pop = q_valid && adv;

    // four banks by column and row parity: the four corners of any cell hit
    // four different banks, so one query reads all of them in the same cycle
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam int PX = b % 2;
        localparam int PZ = b / 2;

        logic [htsamp_pkg::HGT_W-1:0]   mem [htsamp_pkg::BANK_DEPTH];
        logic [htsamp_pkg::XB-2:0]      col;
        logic [htsamp_pkg::ZB-2:0]      row;
        logic [htsamp_pkg::BANK_AW-1:0] raddr;
        logic [htsamp_pkg::BANK_AW-1:0] waddr;

        assign col   = q_data.x[htsamp_pkg::XB-1:1] +
                       {{(htsamp_pkg::XB-2){1'b0}}, (PX == 0) & q_data.x[0]};
        assign row   = q_data.z[htsamp_pkg::ZB-1:1] +
                       {{(htsamp_pkg::ZB-2){1'b0}}, (PZ == 0) & q_data.z[0]};
        assign raddr = {row, col};
        assign waddr = {q_data.z[htsamp_pkg::ZB-1:1], q_data.x[htsamp_pkg::XB-1:1]};
        assign bank_we[b] = pop && q_data.wr_en &&
                            (q_data.x[0] == 1'(PX)) && (q_data.z[0] == 1'(PZ));

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
            begin
                mem[waddr] <= q_data.value;
            end
            if (pop && q_data.is_query)
            begin
                rd_data_reg[b] <= mem[raddr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
            b5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            // loads retire at the write; only queries go on
            b1_valid_reg <= pop && q_data.is_query;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
            b5_valid_reg <= b4_valid_reg;
        end
    end

    // map banks back to corners and rebuild one corner along the diagonal
    always_comb
    begin
        bl = $signed({2'b00, rd_data_reg[{b1_z0_reg, b1_x0_reg}]});
        br = $signed({2'b00, rd_data_reg[{b1_z0_reg, !b1_x0_reg}]});
        tl = $signed({2'b00, rd_data_reg[{!b1_z0_reg, b1_x0_reg}]});
        tr = $signed({2'b00, rd_data_reg[{!b1_z0_reg, !b1_x0_reg}]});
        unique case (b1_repl_reg)
            htsamp_pkg::REPL_BR: br = bl + tr - tl;
            htsamp_pkg::REPL_TL: tl = tr + bl - br;
            htsamp_pkg::REPL_TR: tr = tl + br - bl;
            htsamp_pkg::REPL_BL: bl = tl + br - tr;
            default:             br = bl;
        endcase
    end

    assign tl_w  = tl;
    assign bl_w  = bl;
    assign d_top = DW'(tr) - DW'(tl);
    assign d_bot = DW'(br) - DW'(bl);
    assign xf_s  = $signed({1'b0, b1_xf_reg});
    assign top   = (tl_w <<< htsamp_pkg::FRAC_W) + xf_s * d_top;
    assign bot   = (bl_w <<< htsamp_pkg::FRAC_W) + xf_s * d_bot;

    assign diff  = DIFF_W'(b2_top_reg) - DIFF_W'(b2_bot_reg);
    assign bot_h = b2_bot_reg;
    assign zf_s  = $signed({1'b0, b2_zf_reg});
    assign h     = (bot_h <<< htsamp_pkg::FRAC_W) + zf_s * diff;

    // a negative height reads as zero
    assign hu  = b3_h_reg[H_W-1] ? '0 : b3_h_reg[HU_W-1:0];
    assign sum = {b4_hi_reg, {HALF{1'b0}}} + {{HALF{1'b0}}, b4_lo_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (pop)
            begin
                b1_in_range_reg <= q_data.in_range;
                b1_repl_reg     <= q_data.repl;
                b1_x0_reg       <= q_data.x[0];
                b1_z0_reg       <= q_data.z[0];
                b1_xf_reg       <= q_data.xf;
                b1_zf_reg       <= q_data.zf;
            end
            b2_in_range_reg <= b1_in_range_reg;
            b2_zf_reg       <= b1_zf_reg;
            b2_top_reg      <= top;
            b2_bot_reg      <= bot;
            b3_in_range_reg <= b2_in_range_reg;
            b3_h_reg        <= h;
            b4_in_range_reg <= b3_in_range_reg;
            b4_lo_reg       <= hu[HALF-1:0] * scale_y;
            b4_hi_reg       <= hu[HU_W-1:HALF] * scale_y;
            b5_in_range_reg <= b4_in_range_reg;
            b5_height_reg   <= b4_in_range_reg ? sum[SUM_W-1 -: htsamp_pkg::OUT_W] : '0;
        end
    end

    assign m_tvalid = b5_valid_reg;
    assign m_tdata  = b5_height_reg;
    assign m_tuser  = b5_in_range_reg;

    `HTS_ASSERT_ALWAYS(a_one_bank_write, $onehot0(bank_we), "load wrote more than one bank")
    `HTS_ASSERT_IMPLY(a_out_zero, b5_valid_reg && !b5_in_range_reg, b5_height_reg == '0, "outside query with nonzero height")

endmodule

@@ rtl/heightmap_triangle_sampler_core.sv @@
// Top level of the heightmap triangle sampler: config registers, front end, queue, back end.
// Throughput: one request per cycle, loads and queries alike, when the output is not stalled.
// Path of a query: scale stage, queue slot, bank read, two interpolation stages,
// partial-product scale and output register, each registered.
// Reset empties the pipeline and the queue and returns the config registers to their
// defaults; the height store holds no reset value and must be loaded before it is read.
module heightmap_triangle_sampler_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_wr_en,
    input  logic [htsamp_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [htsamp_pkg::CFG_W-1:0]      cfg_wdata,
    // request stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample_x[7:0], sample_z[15:8], sample_value[23:16], pos_x[47:24], pos_z[71:48]
    input  logic [htsamp_pkg::IN_W-1:0]       s_tdata,
    // opcode[0]
    input  logic                              s_tuser,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // height_out[31:0]
    output logic [htsamp_pkg::OUT_W-1:0]      m_tdata,
    // in_range[0]
    output logic                              m_tuser
);

    htsamp_pkg::cfg_t   cfg_reg;
    logic               push;
    htsamp_pkg::cmd_t   push_data;
    logic               full;
    logic               pop;
    logic               q_valid;
    htsamp_pkg::cmd_t   q_head;

    // Config registers, read directly by front and back ends. The user writes them only
    // while the block is idle; the block does not enforce it. Unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width  <= htsamp_pkg::DIM_W'(256);
            cfg_reg.grid_depth  <= htsamp_pkg::DIM_W'(256);
            cfg_reg.inv_scale_x <= htsamp_pkg::INV_W'(65536);
            cfg_reg.inv_scale_z <= htsamp_pkg::INV_W'(65536);
            cfg_reg.scale_y     <= htsamp_pkg::SY_W'(256);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                htsamp_pkg::CFG_GRID_WIDTH:
                    cfg_reg.grid_width <= cfg_wdata[htsamp_pkg::DIM_W-1:0];
                htsamp_pkg::CFG_GRID_DEPTH:
                    cfg_reg.grid_depth <= cfg_wdata[htsamp_pkg::DIM_W-1:0];
                htsamp_pkg::CFG_INV_SCALE_X:
                    cfg_reg.inv_scale_x <= cfg_wdata[htsamp_pkg::INV_W-1:0];
                htsamp_pkg::CFG_INV_SCALE_Z:
                    cfg_reg.inv_scale_z <= cfg_wdata[htsamp_pkg::INV_W-1:0];
                htsamp_pkg::CFG_SCALE_Y:
                    cfg_reg.scale_y <= cfg_wdata[htsamp_pkg::SY_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front end: take the request, scale x and z into grid space, test the
    // cell against the grid, pick the triangle, and flip load rows.
    htsamp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    // Short queue: lets the front keep accepting while the output is held.
    htsamp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // Back end: write loads into the banked store, read four corners for
    // queries, interpolate and apply the vertical scale.
    htsamp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .scale_y  (cfg_reg.scale_y),
        .q_valid  (q_valid),
        .q_data   (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
